// File: sv/vtd_pkg.sv
`default_nettype none
package vtd_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = 2 * WORD_W;          // one coefficient times one coordinate
    localparam int T_W        = PROD_W + 2;          // sum of four products
    localparam int MAG_W      = T_W - 1;             // magnitude of a sum
    localparam int NUM_W      = MAG_W + FRAC_BITS;   // dividend after scaling
    localparam int QBITS      = WORD_W;              // quotient bits resolved
    localparam int DK_W       = MAG_W + QBITS;       // shifted divisor width

    localparam int NUM_CFG    = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_SEL_W  = $clog2(NUM_CFG);

    localparam int MIDQ_DEPTH = 8;
    localparam int MIDQ_PTR_W = $clog2(MIDQ_DEPTH);
    localparam int MIDQ_CNT_W = $clog2(MIDQ_DEPTH + 1);

    localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] ONE_FX  = WORD_W'(1) << FRAC_BITS;

    // identity matrix
    localparam logic [CFG_W-1:0] MAT_RESET [NUM_CFG] = '{
        {32'd0, ONE_FX}, 64'd0,
        {ONE_FX, 32'd0}, 64'd0,
        64'd0, {32'd0, ONE_FX},
        64'd0, {ONE_FX, 32'd0}
    };

    typedef struct packed {
        logic signed [WORD_W-1:0] vertex_x;
        logic signed [WORD_W-1:0] vertex_y;
        logic signed [WORD_W-1:0] vertex_z;
    } t_vertex;

    typedef struct packed {
        logic signed [WORD_W-1:0] proj_x;
        logic signed [WORD_W-1:0] proj_y;
        logic signed [WORD_W-1:0] proj_z;
        logic                     w_zero;
        logic                     saturated;
    } t_proj;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][MAG_W-1:0]  num;
        logic [MAG_W-1:0]       den;
        logic                   w_zero;
    } t_mid;

endpackage
`default_nettype wire

// File: sv/vtd_front.sv
`default_nettype none
module vtd_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire vtd_pkg::t_vertex               i_vertex,
    input  wire logic                           i_cfg_we,
    input  wire logic [vtd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [vtd_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_deq,
    output logic                                o_mid_v,
    output vtd_pkg::t_mid                       o_mid
);
    import vtd_pkg::*;

    logic [CFG_W-1:0]         r_mat [NUM_CFG];
    logic [MIDQ_CNT_W-1:0]    r_credit, n_credit;
    logic [3:0]               r_v;
    logic signed [WORD_W-1:0] r_vin [3];
    logic signed [PROD_W-1:0] r_prod [4][4];
    logic signed [PROD_W-1:0] n_prod [4][4];
    logic signed [T_W-1:0]    r_t [4];
    logic signed [T_W-1:0]    n_t [4];
    t_mid                     r_mid, n_mid;
    logic                     accept;

    assign o_full  = (r_credit == MIDQ_CNT_W'(MIDQ_DEPTH));
    assign accept  = i_push && !o_full;
    assign o_mid_v = r_v[3];
    assign o_mid   = r_mid;

    // credit covers items in this pipe plus items in the queue
    always_comb begin
        n_credit = r_credit;
        if (accept && !i_deq) begin
            n_credit = r_credit + 1'b1;
        end else if (!accept && i_deq) begin
            n_credit = r_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat    <= MAT_RESET;
            r_credit <= '0;
            r_v      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_CFG))) begin
                r_mat[i_cfg_idx[CFG_SEL_W-1:0]] <= i_cfg_data;
            end
            r_credit <= n_credit;
            r_v      <= {r_v[2:0], accept};
        end
    end

    // products; column 3 meets w = 1.0, a shift
    always_comb begin
        logic signed [WORD_W-1:0] c;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                c = (j % 2 == 1) ? r_mat[i*2 + j/2][2*WORD_W-1:WORD_W]
                                 : r_mat[i*2 + j/2][WORD_W-1:0];
                if (j == 3) begin
                    n_prod[i][j] = PROD_W'(c) <<< FRAC_BITS;
                end else begin
                    n_prod[i][j] = PROD_W'(c) * PROD_W'(r_vin[j]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_t[i] = T_W'(r_prod[i][0]) + T_W'(r_prod[i][1])
                   + T_W'(r_prod[i][2]) + T_W'(r_prod[i][3]);
        end
    end

    always_comb begin
        logic signed [T_W-1:0] a;
        for (int i = 0; i < 3; i++) begin
            a = r_t[i][T_W-1] ? -r_t[i] : r_t[i];
            n_mid.num[i] = a[MAG_W-1:0];
            n_mid.neg[i] = r_t[i][T_W-1] ^ r_t[3][T_W-1];
        end
        a = r_t[3][T_W-1] ? -r_t[3] : r_t[3];
        n_mid.den    = a[MAG_W-1:0];
        n_mid.w_zero = (r_t[3] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vin[0] <= i_vertex.vertex_x;
            r_vin[1] <= i_vertex.vertex_y;
            r_vin[2] <= i_vertex.vertex_z;
        end
        r_prod <= n_prod;
        r_t    <= n_t;
        r_mid  <= n_mid;
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= MIDQ_CNT_W'(MIDQ_DEPTH))
        else $error("credit above queue depth");
    a_refused_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full && !i_deq) |=> (r_credit == $past(r_credit)))
        else $error("request taken while full");
    a_zero_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mid_v |-> (o_mid.w_zero == (o_mid.den == '0)))
        else $error("w_zero disagrees with divisor");

endmodule
`default_nettype wire

// File: sv/vtd_fifo.sv
`default_nettype none
module vtd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vtd_pkg::t_mid  i_data,
    input  wire logic           i_pop,
    output logic                o_empty,
    output vtd_pkg::t_mid       o_data
);
    import vtd_pkg::*;

    t_mid                  r_mem [MIDQ_DEPTH];
    logic [MIDQ_PTR_W-1:0] r_wr, r_rd;
    logic [MIDQ_CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule
`default_nettype wire

// File: sv/vtd_back.sv
`default_nettype none
module vtd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_mid_empty,
    input  wire vtd_pkg::t_mid  i_mid,
    output logic                o_deq,
    output logic                o_empty,
    input  wire logic           i_pop,
    output vtd_pkg::t_proj      o_proj
);
    import vtd_pkg::*;

    logic                   r_vs   [QBITS+1];
    logic [NUM_W-1:0]       r_rem  [QBITS+1][3];
    logic [QBITS-1:0]       r_quo  [QBITS+1][3];
    logic [2:0]             r_big  [QBITS+1];
    logic [2:0]             r_neg  [QBITS+1];
    logic [MAG_W-1:0]       r_den  [QBITS+1];
    logic                   r_wz   [QBITS+1];
    logic                   r_out_v;
    t_proj                  r_out, n_out;
    logic                   en;
    logic [NUM_W-1:0]       n_rem0 [3];
    logic [2:0]             n_big0;

    // whole divider moves together; it holds while the result waits
    assign en      = !r_out_v || i_pop;
    assign o_deq   = en && !i_mid_empty;
    assign o_empty = !r_out_v;
    assign o_proj  = r_out;

    // quotient above 32 bits is caught up front and only saturates
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_rem0[c] = NUM_W'(i_mid.num[c]) << FRAC_BITS;
            n_big0[c] = DK_W'(n_rem0[c]) >= (DK_W'(i_mid.den) << QBITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs[0] <= 1'b0;
        end else if (en) begin
            r_vs[0] <= !i_mid_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[0][c] <= n_rem0[c];
                r_quo[0][c] <= '0;
            end
            r_big[0] <= n_big0;
            r_neg[0] <= i_mid.neg;
            r_den[0] <= i_mid.den;
            r_wz[0]  <= i_mid.w_zero;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar s = 0; s < QBITS; s++) begin : g_div
        localparam int K = QBITS - 1 - s;
        logic [NUM_W-1:0] n_rem [3];
        logic [2:0]       ge;

        always_comb begin
            logic [DK_W-1:0] dk;
            logic [DK_W-1:0] diff;
            dk = DK_W'(r_den[s]) << K;
            for (int c = 0; c < 3; c++) begin
                ge[c]    = DK_W'(r_rem[s][c]) >= dk;
                diff     = DK_W'(r_rem[s][c]) - dk;
                n_rem[c] = ge[c] ? diff[NUM_W-1:0] : r_rem[s][c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[s+1] <= 1'b0;
            end else if (en) begin
                r_vs[s+1] <= r_vs[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int c = 0; c < 3; c++) begin
                    r_rem[s+1][c] <= n_rem[c];
                    r_quo[s+1][c] <= {r_quo[s][c][QBITS-2:0], ge[c]};
                end
                r_big[s+1] <= r_big[s];
                r_neg[s+1] <= r_neg[s];
                r_den[s+1] <= r_den[s];
                r_wz[s+1]  <= r_wz[s];
            end
        end
    end

    // sign and clamp
    always_comb begin
        logic [WORD_W-1:0] v [3];
        logic [QBITS-1:0]  q;
        logic              sat;
        sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            q = r_quo[QBITS][c];
            if (r_neg[QBITS][c]) begin
                if (r_big[QBITS][c] || (q > SAT_NEG)) begin
                    v[c] = SAT_NEG;
                    sat  = 1'b1;
                end else begin
                    v[c] = WORD_W'(0) - q;
                end
            end else begin
                if (r_big[QBITS][c] || (q > SAT_POS)) begin
                    v[c] = SAT_POS;
                    sat  = 1'b1;
                end else begin
                    v[c] = q;
                end
            end
        end
        if (r_wz[QBITS]) begin
            n_out = '{proj_x: '0, proj_y: '0, proj_z: '0, w_zero: 1'b1, saturated: 1'b0};
        end else begin
            n_out = '{proj_x: v[0], proj_y: v[1], proj_z: v[2],
                      w_zero: 1'b0, saturated: sat};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_vs[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_pop) |=> (r_out_v && $stable(r_out)))
        else $error("waiting result lost or changed");
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.w_zero) |-> (r_out.proj_x == '0 && r_out.proj_y == '0
                                       && r_out.proj_z == '0 && !r_out.saturated))
        else $error("w_zero result not cleared");
    a_no_deq_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_deq |-> (!i_mid_empty && (!r_out_v || i_pop)))
        else $error("dequeue while stalled or empty");

endmodule
`default_nettype wire

// File: sv/vertex_transform_divide_core.sv
// vertex_transform_divide_core
// Transforms a vertex (x, y, z, 1) by a 4x4 Q16.16 matrix and divides x, y, z
// by w, giving Q16.16 results truncated toward zero and clamped to 32 bits.
// Input: a request is taken at a clock edge with push high and full low.
// Output: while empty is low the oldest result sits on o_proj; it is taken at
// an edge with pop high. One result per request, in order.
// Configuration: i_cfg_we writes i_cfg_data into matrix register i_cfg_idx
// (0..7, two coefficients each); other indexes are dropped. Write only idle.
// Throughput: one request per cycle while full is low. Path: the accepting
// edge loads the input register, then the front end registers (products,
// sums, classification), the queue, then 1 scaling/range stage, 32 quotient
// stages (one bit each, three lanes) and the output register.
// Stall: a held result freezes the divider pipe; the front end keeps taking
// requests until its 8-entry queue credit runs out, then raises full.
// Reset (synchronous, i_rst_n low) loads the identity matrix and empties
// all stages and the queue.
`default_nettype none
module vertex_transform_divide_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire vtd_pkg::t_vertex               i_vertex,
    output logic                                empty,
    input  wire logic                           pop,
    output vtd_pkg::t_proj                      o_proj,
    input  wire logic                           i_cfg_we,
    input  wire logic [vtd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [vtd_pkg::CFG_W-1:0]      i_cfg_data
);
    import vtd_pkg::*;

    logic mid_v;
    t_mid mid_in;
    t_mid mid_out;
    logic mid_empty;
    logic deq;

    // front: matrix registers, products, sums, sign/zero classification
    vtd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_vertex   (i_vertex),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_deq      (deq),
        .o_mid_v    (mid_v),
        .o_mid      (mid_in)
    );

    // queue decoupling the two halves
    vtd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_v),
        .i_data  (mid_in),
        .i_pop   (deq),
        .o_empty (mid_empty),
        .o_data  (mid_out)
    );

    // back: bit-per-stage divider, clamp, output register
    vtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_mid       (mid_out),
        .o_deq       (deq),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_proj      (o_proj)
    );

endmodule
`default_nettype wire
